>>> hw/rtl/bis_pkg.sv
// ----------------------------------------------------------------------------
// bis_pkg
// Shared types and constants of the bilinear image sampler.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bis_pkg;

   localparam int FRAC_BITS  = 16;
   localparam int COORD_W    = 17;
   localparam int SIDE_REG_W = 9;
   localparam int PIX_IDX_W  = 8;
   localparam int VALUE_W    = 16;

   localparam logic [SIDE_REG_W-1:0] SIDE_RESET = 9'd256;

   typedef enum logic [0:0] {
      CSR_IMAGE_WIDTH  = 1'b0,
      CSR_IMAGE_HEIGHT = 1'b1
   } csr_index_type;

   typedef enum logic [0:0] {
      FUNC_WRITE  = 1'b0,
      FUNC_SAMPLE = 1'b1
   } func_type;

   // sample control that travels with the pixel data through the blend stages
   typedef struct packed {
      logic                 valid;
      logic                 outside;
      logic [FRAC_BITS-1:0] frac_u;
      logic [FRAC_BITS-1:0] frac_v;
   } bis_tap_type;

endpackage

`default_nettype wire

>>> hw/rtl/bis_pixel_ram.sv
// ----------------------------------------------------------------------------
// bis_pixel_ram
// Pixel memory with one write port and two registered read ports.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bis_pixel_ram #(
   parameter int ADDR_W = 16,
   parameter int DATA_W = 16
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic [ADDR_W-1:0] rd_addr_a,
   input  logic [ADDR_W-1:0] rd_addr_b,
   output logic [DATA_W-1:0] rd_data_a,
   output logic [DATA_W-1:0] rd_data_b
);

   logic [DATA_W-1:0] mem [0:(1 << ADDR_W)-1];
   logic [DATA_W-1:0] rd_data_a_ff;
   logic [DATA_W-1:0] rd_data_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_a_ff <= mem[rd_addr_a];
      rd_data_b_ff <= mem[rd_addr_b];
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

`default_nettype wire

>>> hw/rtl/bis_blend.sv
// ----------------------------------------------------------------------------
// bis_blend
// Four-stage bilinear blend of the neighbour pixels, rounding and result
// register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bis_blend
   import bis_pkg::*;
#(
   parameter int PIX_W = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  bis_tap_type               tap,
   input  logic [PIX_W-1:0]          pix_00,
   input  logic [PIX_W-1:0]          pix_10,
   input  logic [PIX_W-1:0]          pix_01,
   input  logic [PIX_W-1:0]          pix_11,
   output logic                      rsp_strobe,
   output logic signed [VALUE_W-1:0] rsp_sample_value,
   output logic                      rsp_outside
);

   localparam int H_W   = PIX_W + FRAC_BITS;
   localparam int P_W   = PIX_W + FRAC_BITS + 2;
   localparam int ACC_W = PIX_W + 2 * FRAC_BITS;
   localparam logic [PIX_W-1:0] SIGN_BIT   = PIX_W'(1) << (PIX_W - 1);
   localparam logic [ACC_W-1:0] ROUND_BIAS = ACC_W'(1) << (2 * FRAC_BITS - 1);

   // horizontal difference times fraction
   logic [PIX_W-1:0]        b00, b10, b01, b11;
   logic signed [PIX_W:0]   dx_top, dx_bot;
   logic signed [FRAC_BITS:0] fu_s;
   logic signed [P_W-1:0]   prod_top_full, prod_bot_full;

   bis_tap_type             s4_tap_ff;
   logic [PIX_W-1:0]        s4_base_top_ff, s4_base_bot_ff;
   logic [H_W-1:0]          s4_prod_top_ff, s4_prod_bot_ff;

   always_comb begin
      b00 = pix_00 ^ SIGN_BIT;
      b10 = pix_10 ^ SIGN_BIT;
      b01 = pix_01 ^ SIGN_BIT;
      b11 = pix_11 ^ SIGN_BIT;
      dx_top = $signed({1'b0, b10}) - $signed({1'b0, b00});
      dx_bot = $signed({1'b0, b11}) - $signed({1'b0, b01});
      fu_s = $signed({1'b0, tap.frac_u});
      prod_top_full = dx_top * fu_s;
      prod_bot_full = dx_bot * fu_s;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_tap_ff.valid <= 1'b0;
      end else begin
         s4_tap_ff.valid <= tap.valid;
      end
      s4_tap_ff.outside <= tap.outside;
      s4_tap_ff.frac_u  <= tap.frac_u;
      s4_tap_ff.frac_v  <= tap.frac_v;
      s4_base_top_ff    <= b00;
      s4_base_bot_ff    <= b01;
      s4_prod_top_ff    <= prod_top_full[H_W-1:0];
      s4_prod_bot_ff    <= prod_bot_full[H_W-1:0];
   end

   // horizontal lerp of both rows
   logic [H_W-1:0] h_top_in, h_bot_in;
   bis_tap_type    s5_tap_ff;
   logic [H_W-1:0] s5_h_top_ff, s5_h_bot_ff;

   always_comb begin
      h_top_in = {s4_base_top_ff, {FRAC_BITS{1'b0}}} + s4_prod_top_ff;
      h_bot_in = {s4_base_bot_ff, {FRAC_BITS{1'b0}}} + s4_prod_bot_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_tap_ff.valid <= 1'b0;
      end else begin
         s5_tap_ff.valid <= s4_tap_ff.valid;
      end
      s5_tap_ff.outside <= s4_tap_ff.outside;
      s5_tap_ff.frac_u  <= s4_tap_ff.frac_u;
      s5_tap_ff.frac_v  <= s4_tap_ff.frac_v;
      s5_h_top_ff       <= h_top_in;
      s5_h_bot_ff       <= h_bot_in;
   end

   // vertical difference split in two partial products
   logic signed [H_W:0]         dv;
   logic signed [PIX_W:0]       dv_hi;
   logic [FRAC_BITS-1:0]        dv_lo;
   logic signed [FRAC_BITS:0]   fv_s;
   logic signed [P_W-1:0]       prod_hi_full;
   logic [2*FRAC_BITS-1:0]      prod_lo_in;

   bis_tap_type                 s6_tap_ff;
   logic [H_W-1:0]              s6_h_top_ff;
   logic [H_W-1:0]              s6_hi_ff;
   logic [2*FRAC_BITS-1:0]      s6_lo_ff;

   always_comb begin
      dv = $signed({1'b0, s5_h_bot_ff}) - $signed({1'b0, s5_h_top_ff});
      dv_hi = dv[H_W:FRAC_BITS];
      dv_lo = dv[FRAC_BITS-1:0];
      fv_s = $signed({1'b0, s5_tap_ff.frac_v});
      prod_hi_full = dv_hi * fv_s;
      prod_lo_in = dv_lo * s5_tap_ff.frac_v;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s6_tap_ff.valid <= 1'b0;
      end else begin
         s6_tap_ff.valid <= s5_tap_ff.valid;
      end
      s6_tap_ff.outside <= s5_tap_ff.outside;
      s6_tap_ff.frac_u  <= s5_tap_ff.frac_u;
      s6_tap_ff.frac_v  <= s5_tap_ff.frac_v;
      s6_h_top_ff       <= s5_h_top_ff;
      s6_hi_ff          <= prod_hi_full[H_W-1:0];
      s6_lo_ff          <= prod_lo_in;
   end

   // sum, round half up, back to two's complement
   logic [ACC_W-1:0]         acc;
   logic [PIX_W-1:0]         rounded;
   logic [PIX_W-1:0]         flipped;
   logic [PIX_W+VALUE_W-1:0] out_wide;
   logic [VALUE_W-1:0]       value_in;

   logic                     rsp_strobe_ff;
   logic [VALUE_W-1:0]       rsp_value_ff;
   logic                     rsp_outside_ff;

   always_comb begin
      acc = {s6_h_top_ff, {FRAC_BITS{1'b0}}} + {s6_hi_ff, {FRAC_BITS{1'b0}}}
          + ACC_W'(s6_lo_ff) + ROUND_BIAS;
      rounded = acc[ACC_W-1:2*FRAC_BITS];
      flipped = rounded ^ SIGN_BIT;
      out_wide = {{VALUE_W{1'b0}}, flipped};
      value_in = s6_tap_ff.outside ? '0 : out_wide[VALUE_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= s6_tap_ff.valid;
      end
      rsp_value_ff   <= value_in;
      rsp_outside_ff <= s6_tap_ff.outside;
   end

   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_sample_value = $signed(rsp_value_ff);
   assign rsp_outside      = rsp_outside_ff;

endmodule

`default_nettype wire

>>> hw/rtl/bilinear_image_sampler.sv
// ----------------------------------------------------------------------------
// bilinear_image_sampler
// Pixel store with a fully pipelined bilinear sampler.
// ----------------------------------------------------------------------------
// One item is taken in every clock cycle while busy is low; busy is high only
// during reset and for the first cycle after it. A pixel write produces no
// result. A sample produces one result strobe, in order; the receiver cannot
// stall, so results are never held. The rate of one item per cycle is set by
// the two copies of the pixel store, each with two read ports, so all four
// neighbours are read in the same cycle. A sample sees every pixel written by
// earlier items. Pixels never written read back undefined; there is no
// clearing pass after reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bilinear_image_sampler
   import bis_pkg::*;
#(
   parameter int MAX_SIDE   = 256,
   parameter int PIXEL_BITS = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic                      req_func,
   input  logic [PIX_IDX_W-1:0]      req_pixel_col,
   input  logic [PIX_IDX_W-1:0]      req_pixel_row,
   input  logic signed [VALUE_W-1:0] req_pixel_value,
   input  logic [COORD_W-1:0]        req_sample_u,
   input  logic [COORD_W-1:0]        req_sample_v,
   output logic                      rsp_strobe,
   output logic signed [VALUE_W-1:0] rsp_sample_value,
   output logic                      rsp_outside,
   input  logic                      csr_write_en,
   input  logic [0:0]                csr_index,
   input  logic [SIDE_REG_W-1:0]     csr_wdata
);

   localparam int SW     = $clog2(MAX_SIDE);
   localparam int ADDR_W = 2 * SW;
   localparam int SU_W   = COORD_W + SW;

   function automatic logic [SW:0] side_limit(input logic [SIDE_REG_W-1:0] raw);
      logic [31:0] wide;
      wide = 32'(raw);
      if (wide < 32'd2) begin
         return (SW + 1)'(2);
      end else if (wide > 32'(MAX_SIDE)) begin
         return (SW + 1)'(MAX_SIDE);
      end
      return (SW + 1)'(wide);
   endfunction

   // control registers and sides in use
   logic [SIDE_REG_W-1:0] image_width_ff, image_height_ff;
   logic [SW:0]           w_use_in, h_use_in, w_use_ff, h_use_ff;
   logic [SW-1:0]         w_last_ff, h_last_ff;
   logic                  busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= SIDE_RESET;
         image_height_ff <= SIDE_RESET;
         busy_ff         <= 1'b1;
      end else begin
         busy_ff <= 1'b0;
         if (csr_write_en) begin
            case (csr_index)
               CSR_IMAGE_WIDTH: begin
                  image_width_ff <= csr_wdata;
               end
               CSR_IMAGE_HEIGHT: begin
                  image_height_ff <= csr_wdata;
               end
               default: begin
               end
            endcase
         end
      end
   end

   always_comb begin
      w_use_in = side_limit(image_width_ff);
      h_use_in = side_limit(image_height_ff);
   end

   always_ff @(posedge clock) begin
      w_use_ff  <= w_use_in;
      h_use_ff  <= h_use_in;
      w_last_ff <= SW'(w_use_in - (SW + 1)'(1));
      h_last_ff <= SW'(h_use_in - (SW + 1)'(1));
   end

   // stage 1: input transfer
   logic                   accept;
   logic                   p1_valid_ff;
   logic                   p1_func_ff;
   logic [PIX_IDX_W-1:0]   p1_col_ff, p1_row_ff;
   logic [VALUE_W-1:0]     p1_value_ff;
   logic [COORD_W-1:0]     p1_u_ff, p1_v_ff;

   assign accept = start & ~busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
      end else begin
         p1_valid_ff <= accept;
      end
      p1_func_ff  <= req_func;
      p1_col_ff   <= req_pixel_col;
      p1_row_ff   <= req_pixel_row;
      p1_value_ff <= req_pixel_value;
      p1_u_ff     <= req_sample_u;
      p1_v_ff     <= req_sample_v;
   end

   // stage 2: coordinate scaling and write address
   logic [SW+PIX_IDX_W-1:0]     col_wide, row_wide;
   logic [PIXEL_BITS+VALUE_W-1:0] value_wide;
   logic                        wen_in;
   logic [SU_W-1:0]             su_in, sv_in;

   logic                        p2_valid_ff;
   logic                        p2_func_ff;
   logic                        p2_wen_ff;
   logic [ADDR_W-1:0]           p2_waddr_ff;
   logic [PIXEL_BITS-1:0]       p2_wdata_ff;
   logic [SU_W-1:0]             p2_su_ff, p2_sv_ff;

   always_comb begin
      col_wide = {{SW{1'b0}}, p1_col_ff};
      row_wide = {{SW{1'b0}}, p1_row_ff};
      value_wide = {{PIXEL_BITS{1'b0}}, p1_value_ff};
      wen_in = p1_valid_ff && (p1_func_ff == FUNC_WRITE)
            && (32'(p1_col_ff) < 32'(MAX_SIDE)) && (32'(p1_row_ff) < 32'(MAX_SIDE));
      su_in = SU_W'(p1_u_ff) * SU_W'(w_last_ff);
      sv_in = SU_W'(p1_v_ff) * SU_W'(h_last_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p2_valid_ff <= 1'b0;
         p2_wen_ff   <= 1'b0;
      end else begin
         p2_valid_ff <= p1_valid_ff;
         p2_wen_ff   <= wen_in;
      end
      p2_func_ff  <= p1_func_ff;
      p2_waddr_ff <= {row_wide[SW-1:0], col_wide[SW-1:0]};
      p2_wdata_ff <= value_wide[PIXEL_BITS-1:0];
      p2_su_ff    <= su_in;
      p2_sv_ff    <= sv_in;
   end

   // stage 3: neighbour addresses, store access
   logic [SW:0]        u_idx, v_idx;
   logic [SW-1:0]      col0, col1, row0, row1;
   bis_tap_type        tap_in;
   bis_tap_type        tap_ff;

   always_comb begin
      u_idx = p2_su_ff[SU_W-1:FRAC_BITS];
      v_idx = p2_sv_ff[SU_W-1:FRAC_BITS];
      col0 = u_idx[SW-1:0];
      row0 = v_idx[SW-1:0];
      col1 = (col0 == w_last_ff) ? col0 : col0 + SW'(1);
      row1 = (row0 == h_last_ff) ? row0 : row0 + SW'(1);
      tap_in.valid   = p2_valid_ff && (p2_func_ff == FUNC_SAMPLE);
      tap_in.outside = (u_idx >= w_use_ff) || (v_idx >= h_use_ff);
      tap_in.frac_u  = p2_su_ff[FRAC_BITS-1:0];
      tap_in.frac_v  = p2_sv_ff[FRAC_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tap_ff.valid <= 1'b0;
      end else begin
         tap_ff.valid <= tap_in.valid;
      end
      tap_ff.outside <= tap_in.outside;
      tap_ff.frac_u  <= tap_in.frac_u;
      tap_ff.frac_v  <= tap_in.frac_v;
   end

   logic [PIXEL_BITS-1:0] pix_00, pix_10, pix_01, pix_11;

   // near row copy
   bis_pixel_ram #(
      .ADDR_W (ADDR_W),
      .DATA_W (PIXEL_BITS)
   ) u_ram_near (
      .clock     (clock),
      .wr_en     (p2_wen_ff),
      .wr_addr   (p2_waddr_ff),
      .wr_data   (p2_wdata_ff),
      .rd_addr_a ({row0, col0}),
      .rd_addr_b ({row0, col1}),
      .rd_data_a (pix_00),
      .rd_data_b (pix_10)
   );

   // far row copy
   bis_pixel_ram #(
      .ADDR_W (ADDR_W),
      .DATA_W (PIXEL_BITS)
   ) u_ram_far (
      .clock     (clock),
      .wr_en     (p2_wen_ff),
      .wr_addr   (p2_waddr_ff),
      .wr_data   (p2_wdata_ff),
      .rd_addr_a ({row1, col0}),
      .rd_addr_b ({row1, col1}),
      .rd_data_a (pix_01),
      .rd_data_b (pix_11)
   );

   // stages 4 to 7: blend
   bis_blend #(
      .PIX_W (PIXEL_BITS)
   ) u_blend (
      .clock            (clock),
      .reset            (reset),
      .tap              (tap_ff),
      .pix_00           (pix_00),
      .pix_10           (pix_10),
      .pix_01           (pix_01),
      .pix_11           (pix_11),
      .rsp_strobe       (rsp_strobe),
      .rsp_sample_value (rsp_sample_value),
      .rsp_outside      (rsp_outside)
   );

   assign busy = busy_ff;

endmodule

`default_nettype wire

>>> hw/rtl/bis_checker.sv
// ----------------------------------------------------------------------------
// bis_checker
// Port-level checks of the bilinear image sampler, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bis_checker
   import bis_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic                      busy,
   input  logic                      req_func,
   input  logic                      rsp_strobe,
   input  logic signed [VALUE_W-1:0] rsp_sample_value,
   input  logic                      rsp_outside
);

   // every sample transfer gives a result strobe
   a_sample_result: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_func == FUNC_SAMPLE) |-> ##7 rsp_strobe)
      else $error("sample transfer without result");

   // no result without a sample transfer
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy && (req_func == FUNC_SAMPLE), 7))
      else $error("result without sample transfer");

   a_outside_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_outside |-> rsp_sample_value == '0)
      else $error("outside result not zero");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> busy && !rsp_strobe)
      else $error("activity right after reset");

endmodule

bind bilinear_image_sampler bis_checker u_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .req_func         (req_func),
   .rsp_strobe       (rsp_strobe),
   .rsp_sample_value (rsp_sample_value),
   .rsp_outside      (rsp_outside)
);

`default_nettype wire
